@@ rtl/core/okvt_pkg.sv @@
// Shared types and constants for the ordered key/value table.
package okvt_pkg;

    localparam int OPCODE_W    = 3;
    localparam int REQ_KEY_W   = 32;
    localparam int REQ_VALUE_W = 32;
    localparam int POS_W       = 4;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_UPDATE     = 3'd1,
        OP_INS_UPDATE = 3'd2,
        OP_ERASE      = 3'd3,
        OP_CONTAINS   = 3'd4,
        OP_GET_KEY    = 3'd5,
        OP_GET_POS    = 3'd6
    } t_op;

    typedef struct packed {
        logic load;
        logic look;
        logic exec;
    } t_cmd;

endpackage

@@ rtl/core/okvt_ctrl.sv @@
// Controller state machine that sequences the lookup and execute steps of each item.
module okvt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output okvt_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_load;

    assign busy   = (r_state == S_LOOK);
    assign w_load = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_load ? S_LOOK : S_IDLE;
            S_LOOK:  n_state = S_EXEC;
            S_EXEC:  n_state = w_load ? S_LOOK : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load = w_load;
    assign o_cmd.look = (r_state == S_LOOK);
    assign o_cmd.exec = (r_state == S_EXEC);

    a_look_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state == S_EXEC))
        else $error("lookup step was not followed by the execute step");

endmodule

@@ rtl/core/okvt_datapath.sv @@
// Entry cells with parallel key compare, shift-on-erase, append-on-insert and result registers.
module okvt_datapath #(
    parameter int CAPACITY = 16,
    parameter int KW       = 32,
    parameter int VW       = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  okvt_pkg::t_cmd                      i_cmd,
    input  logic [okvt_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [KW-1:0]                       i_key,
    input  logic [VW-1:0]                       i_value,
    input  logic [okvt_pkg::POS_W-1:0]          i_position,
    output logic                                o_valid,
    output logic                                o_success,
    output logic                                o_table_full,
    output logic [okvt_pkg::REQ_KEY_W-1:0]      o_found_key,
    output logic [okvt_pkg::REQ_VALUE_W-1:0]    o_found_value,
    output logic [okvt_pkg::COUNT_OUT_W-1:0]    o_entry_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Request registers.
    okvt_pkg::t_op                  r_op;
    logic [KW-1:0]                  r_key;
    logic [VW-1:0]                  r_value;
    logic [okvt_pkg::POS_W-1:0]     r_pos;

    // Entry cells and fill count.
    logic [KW-1:0]                  r_key_cells [CAPACITY];
    logic [VW-1:0]                  r_val_cells [CAPACITY];
    logic [KW-1:0]                  w_key_next  [CAPACITY];
    logic [VW-1:0]                  w_val_next  [CAPACITY];
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;

    // Lookup results.
    logic [CAPACITY-1:0]            w_match;
    logic [IW-1:0]                  w_slot;
    logic                           r_hit;
    logic [IW-1:0]                  r_slot;
    logic                           r_pos_ok;

    // Execute controls.
    logic                           w_do_insert;
    logic                           w_do_write;
    logic                           w_do_erase;
    logic [IW-1:0]                  w_rd_addr;
    logic [KW-1:0]                  w_rd_key;
    logic [VW-1:0]                  w_rd_val;

    // Result registers.
    logic                           r_out_valid;
    logic                           r_out_success;
    logic                           r_out_full;
    logic [KW-1:0]                  r_out_key;
    logic [VW-1:0]                  r_out_val;
    logic [CW-1:0]                  r_out_count;
    logic                           n_success;
    logic                           n_full;
    logic [KW-1:0]                  n_key;
    logic [VW-1:0]                  n_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= okvt_pkg::t_op'(i_opcode);
            r_key   <= i_key;
            r_value <= i_value;
            r_pos   <= i_position;
        end
    end

    always_comb begin
        w_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = (CW'(i) < r_count) && (r_key_cells[i] == r_key);
            w_slot     = w_slot | (w_match[i] ? IW'(i) : IW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_hit    <= |w_match;
            r_slot   <= w_slot;
            r_pos_ok <= (32'(r_pos) < 32'(r_count));
        end
    end

    assign w_rd_addr = (r_op == okvt_pkg::OP_GET_POS) ? IW'(r_pos) : r_slot;
    assign w_rd_key  = r_key_cells[w_rd_addr];
    assign w_rd_val  = r_val_cells[w_rd_addr];

    always_comb begin
        w_do_insert = 1'b0;
        w_do_write  = 1'b0;
        w_do_erase  = 1'b0;
        n_success   = 1'b0;
        n_full      = 1'b0;
        n_key       = '0;
        n_val       = '0;
        n_count     = r_count;
        unique case (r_op)
            okvt_pkg::OP_INSERT, okvt_pkg::OP_INS_UPDATE: begin
                if (r_hit) begin
                    if (r_op == okvt_pkg::OP_INS_UPDATE) begin
                        w_do_write = 1'b1;
                        n_success  = 1'b1;
                    end
                end else if (r_count == CW'(CAPACITY)) begin
                    n_full = 1'b1;
                end else begin
                    w_do_insert = 1'b1;
                    n_success   = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            okvt_pkg::OP_UPDATE: begin
                w_do_write = r_hit;
                n_success  = r_hit;
            end
            okvt_pkg::OP_ERASE: begin
                if (r_hit) begin
                    w_do_erase = 1'b1;
                    n_success  = 1'b1;
                    n_count    = r_count - CW'(1);
                end
            end
            okvt_pkg::OP_CONTAINS: begin
                n_success = r_hit;
            end
            okvt_pkg::OP_GET_KEY: begin
                if (r_hit) begin
                    n_success = 1'b1;
                    n_val     = w_rd_val;
                end
            end
            okvt_pkg::OP_GET_POS: begin
                if (r_pos_ok) begin
                    n_success = 1'b1;
                    n_key     = w_rd_key;
                    n_val     = w_rd_val;
                end
            end
            default: begin
                n_success = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
            w_key_next[i] = r_key_cells[i + 1];
            w_val_next[i] = r_val_cells[i + 1];
        end
        w_key_next[CAPACITY-1] = r_key_cells[CAPACITY-1];
        w_val_next[CAPACITY-1] = r_val_cells[CAPACITY-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (w_do_erase && (IW'(i) >= r_slot)) begin
                    r_key_cells[i] <= w_key_next[i];
                    r_val_cells[i] <= w_val_next[i];
                end else if (w_do_insert && (CW'(i) == r_count)) begin
                    r_key_cells[i] <= r_key;
                    r_val_cells[i] <= r_value;
                end else if (w_do_write && (IW'(i) == r_slot)) begin
                    r_val_cells[i] <= r_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_success <= n_success;
            r_out_full    <= n_full;
            r_out_key     <= n_key;
            r_out_val     <= n_val;
            r_out_count   <= n_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_success     = r_out_success;
    assign o_table_full  = r_out_full;
    assign o_found_key   = okvt_pkg::REQ_KEY_W'(r_out_key);
    assign o_found_value = okvt_pkg::REQ_VALUE_W'(r_out_val);
    assign o_entry_count = okvt_pkg::COUNT_OUT_W'(r_out_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.look |-> $onehot0(w_match))
        else $error("key held in more than one entry");

    a_result_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("execute step produced no result");

    a_full_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_full) |-> !r_out_success)
        else $error("full flag raised on a successful item");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("entry count changed outside the execute step");

endmodule

@@ rtl/core/ordered_key_value_table.sv @@
// Top level of the insertion-ordered key/value table.
//
// A request item is taken at a rising edge where start is high and busy is low.
// It carries an opcode, a key, a value and a read position on separate ports.
// Each item gives one result, shown on the o_ ports for exactly one cycle while
// o_valid is high; the receiver takes it at the edge that ends that cycle.
// An item passes through the lookup step, where every entry cell compares its
// key at once and the matching slot is encoded and registered, and then the
// execute step, where the cells append, update or shift down to close a gap
// and the result registers load; o_valid is registered from the execute step.
// busy is high only during the lookup step, so a new item can be taken while
// the previous one is in the execute step, and one result leaves per item.
// Reset clears the entry count and the result strobe; entry contents are not
// cleared and are only read below the count. The receiver cannot stall.
module ordered_key_value_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [okvt_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [okvt_pkg::REQ_KEY_W-1:0]      i_req_key,
    input  logic [okvt_pkg::REQ_VALUE_W-1:0]    i_req_value,
    input  logic [okvt_pkg::POS_W-1:0]          i_position,
    output logic                                o_valid,
    output logic                                o_success,
    output logic                                o_table_full,
    output logic [okvt_pkg::REQ_KEY_W-1:0]      o_found_key,
    output logic [okvt_pkg::REQ_VALUE_W-1:0]    o_found_value,
    output logic [okvt_pkg::COUNT_OUT_W-1:0]    o_entry_count
);

    localparam int KW = (KEY_BITS < okvt_pkg::REQ_KEY_W) ? KEY_BITS : okvt_pkg::REQ_KEY_W;
    localparam int VW = (VALUE_BITS < okvt_pkg::REQ_VALUE_W) ? VALUE_BITS
                                                             : okvt_pkg::REQ_VALUE_W;

    okvt_pkg::t_cmd w_cmd;

    okvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    okvt_datapath #(
        .CAPACITY (CAPACITY),
        .KW       (KW),
        .VW       (VW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (i_opcode),
        .i_key         (i_req_key[KW-1:0]),
        .i_value       (i_req_value[VW-1:0]),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .o_success     (o_success),
        .o_table_full  (o_table_full),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count)
    );

endmodule
